[hdl/trd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers of the record deframer.
package trd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PADDR_W      = 3;

  localparam logic [15:0] RESERVED_TYPE = 16'hFFFF;
  localparam logic [1:0]  HDR_LAST_IDX  = 2'(HEADER_BYTES - 1);

  typedef enum logic [0:0] {
    REG_BIG_ENDIAN = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_VALUE   = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_STOP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_SHORT    = 2'd1,
    CAUSE_OVERRUN  = 2'd2,
    CAUSE_RESERVED = 2'd3
  } cause_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] rtype;
    logic [15:0] rlen;
    logic [7:0]  vbyte;
    logic        last;
    cause_t      cause;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  function automatic logic [15:0] put_byte(input logic [15:0] hold, input logic [7:0] b,
                                           input logic be);
    put_byte = be ? {hold[7:0], b} : {b, hold[15:8]};
  endfunction

endpackage

[hdl/trd_if.sv]
`timescale 1ns / 1ps
// Byte and record channel interfaces of the record deframer.
interface trd_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_byte;
  logic [15:0] bytes_left;
  logic        first_of_buffer;

  modport source (output valid, output in_byte, output bytes_left,
                  output first_of_buffer, input ready);
  modport sink (input valid, input in_byte, input bytes_left,
                input first_of_buffer, output ready);
endinterface

interface trd_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [15:0] record_type;
  logic [15:0] record_length;
  logic [7:0]  value_byte;
  logic        last_of_record;
  logic [1:0]  stop_cause;

  modport source (output valid, output out_kind, output record_type, output record_length,
                  output value_byte, output last_of_record, output stop_cause, input ready);
  modport sink (input valid, input out_kind, input record_type, input record_length,
                input value_byte, input last_of_record, input stop_cause, output ready);
endinterface

[hdl/tlv_record_deframer_unit.sv]
`timescale 1ns / 1ps
// Top level of the TLV record deframer: config register, parser, queue, output stage.
//
// Usage: buffer bytes enter on the bytes channel, one beat per byte, each with the
// count of bytes left in the buffer and a first-of-buffer flag. Each record is a
// 16-bit type and a 16-bit length (byte order from big_endian), then the value.
// The records channel carries one header beat per record, one beat per value byte
// and one stop beat with its cause when a record cannot be read; later bytes of a
// stopped buffer give nothing until the next first-of-buffer byte.
// Throughput: one byte per cycle while the queue is not full; the parser updates its
// counters and compares in the accept cycle. Each result is written to the queue at
// the accept edge and is then loaded into the output register, which drives the
// records channel.
// Stall: a 4-entry queue and the output register absorb a stalled receiver; the
// bytes channel drops ready only when the queue is full.
// Reset (rst, synchronous): parser at a record header, queue and output empty,
// big_endian = 1. The APB port at byte address 0 holds big_endian; write it only
// while the block is idle.
module tlv_record_deframer_unit import trd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  trd_byte_if.sink           bytes,
  trd_rec_if.source          records
);

  logic  big_endian;
  logic  accept;
  logic  full;
  logic  head_valid;
  logic  pop;
  item_t head;
  push_t qpush;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_BIG_ENDIAN) begin
      big_endian <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BIG_ENDIAN) begin
      prdata[0] = big_endian;
    end
  end

  assign bytes.ready = !full;
  assign accept      = bytes.valid && !full;

  trd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .in_byte         (bytes.in_byte),
    .bytes_left      (bytes.bytes_left),
    .first_of_buffer (bytes.first_of_buffer),
    .big_endian      (big_endian),
    .qpush           (qpush)
  );

  trd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .qpush      (qpush),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  trd_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .records    (records)
  );

endmodule

[hdl/trd_parser.sv]
`timescale 1ns / 1ps
// Front end: accepts buffer bytes, tracks record framing and classifies each beat.
module trd_parser import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic [15:0] bytes_left,
  input  logic        first_of_buffer,
  input  logic        big_endian,
  output push_t       qpush
);

  phase_t      phase, phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [15:0] type_hold, type_hold_next;
  logic [15:0] length_hold, length_hold_next;
  logic [15:0] value_remaining, value_remaining_next;

  phase_t      ph;
  logic [1:0]  hidx;
  logic [15:0] type_new, length_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= '0;
      type_hold       <= '0;
      length_hold     <= '0;
      value_remaining <= '0;
    end else begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      type_hold       <= type_hold_next;
      length_hold     <= length_hold_next;
      value_remaining <= value_remaining_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    type_hold_next       = type_hold;
    length_hold_next     = length_hold;
    value_remaining_next = value_remaining;
    qpush                = '0;
    ph                   = first_of_buffer ? PH_HEADER : phase;
    hidx                 = first_of_buffer ? 2'd0 : header_index;
    type_new             = (hidx < 2'd2) ? put_byte(type_hold, in_byte, big_endian) : type_hold;
    length_new           = (hidx < 2'd2) ? length_hold
                                         : put_byte(length_hold, in_byte, big_endian);
    if (accept) begin
      phase_next        = ph;
      header_index_next = hidx;
      case (ph)
        PH_VALUE: begin
          qpush.push       = 1'b1;
          qpush.item.kind  = KIND_VALUE;
          qpush.item.rtype = type_hold;
          qpush.item.rlen  = length_hold;
          qpush.item.vbyte = in_byte;
          qpush.item.last  = (value_remaining == 16'd1);
          qpush.item.cause = CAUSE_NONE;
          value_remaining_next = value_remaining - 16'd1;
          if (value_remaining == 16'd1) begin
            phase_next        = PH_HEADER;
            header_index_next = '0;
          end
        end
        PH_HEADER: begin
          if (hidx == 2'd0 && bytes_left < 16'(HEADER_BYTES)) begin
            phase_next       = PH_STOPPED;
            qpush.push       = 1'b1;
            qpush.item.kind  = KIND_STOP;
            qpush.item.cause = CAUSE_SHORT;
          end else begin
            type_hold_next   = type_new;
            length_hold_next = length_new;
            if (hidx != HDR_LAST_IDX) begin
              header_index_next = hidx + 2'd1;
            end else begin
              header_index_next = '0;
              qpush.push        = 1'b1;
              qpush.item.rtype  = type_new;
              qpush.item.rlen   = length_new;
              if (length_new >= bytes_left) begin
                phase_next       = PH_STOPPED;
                qpush.item.kind  = KIND_STOP;
                qpush.item.cause = CAUSE_OVERRUN;
              end else if (type_new == RESERVED_TYPE) begin
                phase_next       = PH_STOPPED;
                qpush.item.kind  = KIND_STOP;
                qpush.item.cause = CAUSE_RESERVED;
              end else if (length_new == 16'd0) begin
                qpush.item.kind  = KIND_HEADER;
                qpush.item.last  = 1'b1;
                qpush.item.cause = CAUSE_NONE;
              end else begin
                phase_next           = PH_VALUE;
                value_remaining_next = length_new;
                qpush.item.kind      = KIND_HEADER;
                qpush.item.cause     = CAUSE_NONE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/trd_queue.sv]
`timescale 1ns / 1ps
// Short result queue between the parser and the output stage.
module trd_queue import trd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t qpush,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (qpush.push) begin
      mem[wptr] <= qpush.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (qpush.push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(qpush.push) - QCNT_W'(do_pop);
    end
  end

endmodule

[hdl/trd_emitter.sv]
`timescale 1ns / 1ps
// Back end: output register that drives result beats onto the record channel.
module trd_emitter import trd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  item_t head,
  output logic  pop,
  trd_rec_if.source records
);

  logic  valid;
  item_t held;

  assign pop = head_valid && (!valid || records.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || records.ready) begin
      valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held <= head;
    end
  end

  assign records.valid          = valid;
  assign records.out_kind       = held.kind;
  assign records.record_type    = held.rtype;
  assign records.record_length  = held.rlen;
  assign records.value_byte     = held.vbyte;
  assign records.last_of_record = held.last;
  assign records.stop_cause     = held.cause;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the TLV record deframer: directed byte table, then random buffers.
module tb_top import trd_pkg::*; ();

  typedef struct {
    logic [7:0]  b;
    logic [15:0] left;
    logic        first;
  } beat_t;

  typedef enum {ROW_FROM_MODEL, ROW_TYPED, ROW_SILENT} row_chk_t;

  typedef struct {
    beat_t    beat;
    row_chk_t chk;
    item_t    want;
  } dir_row_t;

  localparam int unsigned PHASE_BYTES   = 90;
  localparam int unsigned TOTAL_BYTES   = 650;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [PADDR_W-1:0] BE_ADDR = PADDR_W'(4 * int'(REG_BIG_ENDIAN));
  localparam item_t NO_ITEM = '0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  trd_byte_if bytes ();
  trd_rec_if  records ();

  tlv_record_deframer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bytes   (bytes),
    .records (records)
  );

  logic        be_cfg;
  phase_t      parse_ph;
  logic [1:0]  hdr_idx;
  logic [15:0] type_hold;
  logic [15:0] len_hold;
  logic [15:0] value_left;

  item_t       pending_records[$];
  beat_t       byte_stream[$];
  logic [7:0]  frame_bytes[$];
  dir_row_t    dir_rows[$];

  int err_count    = 0;
  int bytes_sent   = 0;
  int bytes_parsed = 0;
  int n_hdr        = 0;
  int n_val        = 0;
  int n_stop       = 0;
  int cfg_writes   = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic item_t mk_item(kind_t k, logic [15:0] t, logic [15:0] l, logic [7:0] v,
                                    logic last, cause_t c);
    item_t it;
    it.kind  = k;
    it.rtype = t;
    it.rlen  = l;
    it.vbyte = v;
    it.last  = last;
    it.cause = c;
    return it;
  endfunction

  function automatic void add_row(logic [7:0] b, logic [15:0] left, logic first, row_chk_t chk,
                                  item_t want);
    dir_row_t r;
    r.beat.b     = b;
    r.beat.left  = left;
    r.beat.first = first;
    r.chk        = chk;
    r.want       = want;
    dir_rows.push_back(r);
  endfunction

  // Expected record beat, if any, for one accepted byte.
  function automatic void parse_byte(input beat_t s, output logic got, output item_t it);
    got = 1'b0;
    it  = NO_ITEM;
    if (s.first) begin
      parse_ph = PH_HEADER;
      hdr_idx  = 2'd0;
    end
    if (parse_ph == PH_VALUE) begin
      got = 1'b1;
      it  = mk_item(KIND_VALUE, type_hold, len_hold, s.b, value_left == 16'd1, CAUSE_NONE);
      value_left = value_left - 16'd1;
      if (value_left == 16'd0) begin
        parse_ph = PH_HEADER;
        hdr_idx  = 2'd0;
      end
    end else if (parse_ph == PH_HEADER) begin
      if (hdr_idx == 2'd0 && s.left < HEADER_BYTES) begin
        parse_ph = PH_STOPPED;
        got      = 1'b1;
        it       = mk_item(KIND_STOP, 16'h0, 16'h0, 8'h0, 1'b0, CAUSE_SHORT);
      end else begin
        if (hdr_idx < 2'd2)
          type_hold = be_cfg ? {type_hold[7:0], s.b} : {s.b, type_hold[15:8]};
        else
          len_hold = be_cfg ? {len_hold[7:0], s.b} : {s.b, len_hold[15:8]};
        if (hdr_idx != HDR_LAST_IDX) begin
          hdr_idx = hdr_idx + 2'd1;
        end else begin
          hdr_idx = 2'd0;
          got     = 1'b1;
          if ({1'b0, len_hold} + 17'd1 > {1'b0, s.left}) begin
            parse_ph = PH_STOPPED;
            it       = mk_item(KIND_STOP, type_hold, len_hold, 8'h0, 1'b0, CAUSE_OVERRUN);
          end else if (type_hold == RESERVED_TYPE) begin
            parse_ph = PH_STOPPED;
            it       = mk_item(KIND_STOP, type_hold, len_hold, 8'h0, 1'b0, CAUSE_RESERVED);
          end else if (len_hold == 16'd0) begin
            it = mk_item(KIND_HEADER, type_hold, 16'd0, 8'h0, 1'b1, CAUSE_NONE);
          end else begin
            parse_ph   = PH_VALUE;
            value_left = len_hold;
            it         = mk_item(KIND_HEADER, type_hold, len_hold, 8'h0, 1'b0, CAUSE_NONE);
          end
        end
      end
    end
  endfunction

  function automatic void add_record(logic [15:0] typ, logic [15:0] len_field, int n_value,
                                     logic be);
    logic [15:0] w[2];
    w[0] = typ;
    w[1] = len_field;
    foreach (w[i]) begin
      if (be) begin
        frame_bytes.push_back(w[i][15:8]);
        frame_bytes.push_back(w[i][7:0]);
      end else begin
        frame_bytes.push_back(w[i][7:0]);
        frame_bytes.push_back(w[i][15:8]);
      end
    end
    repeat (n_value) frame_bytes.push_back(8'($urandom));
  endfunction

  // Mostly well-formed buffers; some end in a short tail, an overrun, a reserved type,
  // are cut by the next buffer, or are plain noise.
  function automatic void gen_buffer(logic be, logic cont);
    int          mode;
    int          len;
    int          pad;
    int          total;
    logic [15:0] typ;
    beat_t       s;
    frame_bytes.delete();
    mode = $urandom_range(0, 99);
    if (mode >= 85) begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        typ = 16'($urandom);
        if (typ == RESERVED_TYPE) typ = 16'h0000;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        add_record(typ, 16'(len), len, be);
      end
      if (mode >= 60 && mode < 68) begin
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
      end else if (mode >= 68 && mode < 77) begin
        len = $urandom_range(0, 4);
        add_record(16'($urandom), 16'(len + $urandom_range(1, 300)), len, be);
      end else if (mode >= 77) begin
        len = $urandom_range(0, 3);
        add_record(RESERVED_TYPE, 16'(len), len, be);
      end
    end
    total = frame_bytes.size();
    pad   = 0;
    if (!cont && $urandom_range(0, 3) == 0)
      pad = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(0, 65535 - total);
    foreach (frame_bytes[i]) begin
      s.b     = frame_bytes[i];
      s.left  = 16'(total + pad - i);
      s.first = (i == 0) && !cont;
      if (mode >= 85) begin
        s.left  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 5))
                                              : 16'($urandom_range(1, 65535));
        s.first = ($urandom_range(0, 5) == 0);
      end
      byte_stream.push_back(s);
    end
  endfunction

  task automatic send_byte(input beat_t s, output logic got, output item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      bytes.valid <= 1'b0;
      @(posedge clk);
    end
    bytes.valid           <= 1'b1;
    bytes.in_byte         <= s.b;
    bytes.bytes_left      <= s.left;
    bytes.first_of_buffer <= s.first;
    do @(posedge clk); while (bytes.ready !== 1'b1);
    bytes_sent++;
    if (s.first || parse_ph != PH_STOPPED) bytes_parsed++;
    parse_byte(s, got, it);
  endtask

  task automatic drain_records();
    do @(posedge clk); while (pending_records.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [31:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_byte_order(input logic v);
    logic [31:0] rd;
    drain_records();
    apb_write(BE_ADDR, 32'(v));
    be_cfg = v;
    cfg_writes++;
    apb_read(BE_ADDR, rd);
    if (rd !== 32'(v))
      note_error($sformatf("big_endian readback: exp %0h got %0h", 32'(v), rd));
  endtask

  always @(posedge clk) begin
    if (rst) records.ready <= 1'b0;
    else records.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : rec_check
    item_t want;
    if (!rst && records.valid === 1'b1 && records.ready === 1'b1) begin
      case (records.out_kind)
        KIND_HEADER: n_hdr++;
        KIND_VALUE:  n_val++;
        default:     n_stop++;
      endcase
      if (pending_records.size() == 0) begin
        note_error($sformatf("unexpected record beat: kind=%0d type=%h len=%h byte=%h last=%b cause=%0d",
                             records.out_kind, records.record_type, records.record_length,
                             records.value_byte, records.last_of_record, records.stop_cause));
      end else begin
        want = pending_records.pop_front();
        if (records.out_kind !== want.kind || records.record_type !== want.rtype ||
            records.record_length !== want.rlen || records.value_byte !== want.vbyte ||
            records.last_of_record !== want.last || records.stop_cause !== want.cause)
          note_error($sformatf({"record beat mismatch: exp kind=%0d type=%h len=%h byte=%h ",
                                "last=%b cause=%0d, got kind=%0d type=%h len=%h byte=%h ",
                                "last=%b cause=%0d"},
                               want.kind, want.rtype, want.rlen, want.vbyte, want.last,
                               want.cause, records.out_kind, records.record_type,
                               records.record_length, records.value_byte,
                               records.last_of_record, records.stop_cause));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    logic  got;
    item_t it;
    int    phase_no;
    logic  split_hdr;
    int    base;
    beat_t s;

    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    bytes.valid           <= 1'b0;
    bytes.in_byte         <= '0;
    bytes.bytes_left      <= '0;
    bytes.first_of_buffer <= 1'b0;

    be_cfg     = 1'b1;
    parse_ph   = PH_HEADER;
    hdr_idx    = 2'd0;
    type_hold  = 16'h0;
    len_hold   = 16'h0;
    value_left = 16'h0;

    add_row(8'h00, 16'd0, 1'b1, ROW_TYPED,
            mk_item(KIND_STOP, 16'h0, 16'h0, 8'h0, 1'b0, CAUSE_SHORT));
    add_row(8'hAA, 16'd2, 1'b0, ROW_SILENT, NO_ITEM);
    add_row(8'h01, 16'd12, 1'b1, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h02, 16'd11, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h00, 16'd10, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h00, 16'd9, 1'b0, ROW_TYPED,
            mk_item(KIND_HEADER, 16'h0102, 16'h0, 8'h0, 1'b1, CAUSE_NONE));
    add_row(8'h00, 16'd8, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'hFF, 16'd7, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h00, 16'd6, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h02, 16'd5, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'hFF, 16'd4, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h00, 16'd3, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h5A, 16'd2, 1'b0, ROW_TYPED,
            mk_item(KIND_STOP, 16'h0, 16'h0, 8'h0, 1'b0, CAUSE_SHORT));
    add_row(8'h5A, 16'd1, 1'b0, ROW_SILENT, NO_ITEM);
    add_row(8'hFF, 16'd65535, 1'b1, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'hFE, 16'd65534, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'hFF, 16'd65533, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'hFF, 16'd65532, 1'b0, ROW_TYPED,
            mk_item(KIND_STOP, 16'hFFFE, 16'hFFFF, 8'h0, 1'b0, CAUSE_OVERRUN));
    add_row(8'hFF, 16'd4, 1'b1, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'hFF, 16'd3, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h00, 16'd2, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h00, 16'd1, 1'b0, ROW_TYPED,
            mk_item(KIND_STOP, 16'hFFFF, 16'h0, 8'h0, 1'b0, CAUSE_RESERVED));
    add_row(8'h00, 16'd6, 1'b1, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h07, 16'd5, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h00, 16'd4, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h01, 16'd3, 1'b0, ROW_FROM_MODEL, NO_ITEM);
    add_row(8'h3C, 16'd1, 1'b1, ROW_TYPED,
            mk_item(KIND_STOP, 16'h0, 16'h0, 8'h0, 1'b0, CAUSE_SHORT));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].beat, got, it);
      if (dir_rows[i].chk == ROW_TYPED) pending_records.push_back(dir_rows[i].want);
      else if (dir_rows[i].chk == ROW_FROM_MODEL && got) pending_records.push_back(it);
    end
    bytes.valid <= 1'b0;

    phase_no  = 0;
    split_hdr = 1'b0;
    while (bytes_sent + int'(PHASE_BYTES / 2) < int'(TOTAL_BYTES)) begin
      write_byte_order(~be_cfg);
      gap_pct   = (phase_no % 4 == 1) ? 59 : (phase_no % 4 == 3) ? 14 : 0;
      stall_pct = (phase_no % 4 == 2) ? 59 : (phase_no % 4 == 3) ? 14 : 0;
      byte_stream.delete();
      if (split_hdr) gen_buffer(be_cfg, 1'b1);
      while (byte_stream.size() < PHASE_BYTES) gen_buffer(be_cfg, $urandom_range(0, 5) == 0);
      // leave a header half read so the next byte order applies to its later bytes
      split_hdr = (phase_no % 3 == 2);
      if (split_hdr) begin
        base = $urandom_range(4, 65535);
        for (int j = 0; j < $urandom_range(1, 3); j++) begin
          s.b     = 8'($urandom);
          s.left  = 16'(base - j);
          s.first = (j == 0);
          byte_stream.push_back(s);
        end
      end
      foreach (byte_stream[k]) begin
        if (phase_no % 2 == 1 && k == byte_stream.size() / 2) begin
          bytes.valid <= 1'b0;
          do @(posedge clk); while (pending_records.size() != 0);
        end
        send_byte(byte_stream[k], got, it);
        if (got) pending_records.push_back(it);
      end
      bytes.valid <= 1'b0;
      phase_no++;
    end

    drain_records();
    $display("tb_top: %0d bytes sent, %0d parsed, %0d phases, %0d byte order writes",
             bytes_sent, bytes_parsed, phase_no, cfg_writes);
    $display("tb_top: %0d headers, %0d value bytes, %0d stops checked, %0d mismatches",
             n_hdr, n_val, n_stop, err_count);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[tlv_record_deframer_unit.f]
hdl/trd_pkg.sv
hdl/trd_if.sv
hdl/trd_parser.sv
hdl/trd_queue.sv
hdl/trd_emitter.sv
hdl/tlv_record_deframer_unit.sv
tb/tb_top.sv
